// ===== design/cwle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwle_pkg
// Shared types, constants and helpers for the center window luma average.
// ----------------------------------------------------------------------------
package cwle_pkg;

    localparam int SAMPLE_PIXELS = 4096;
    localparam int PIXEL_MAX     = 1023;
    localparam int PIXEL_W       = 10;
    localparam int LUMA_W        = 8;
    localparam int POS_W         = 22;
    localparam int FP_W          = 23;
    localparam int CNT_W         = $clog2(SAMPLE_PIXELS + 1);
    localparam int SUM_W         = $clog2(SAMPLE_PIXELS * PIXEL_MAX + 1);

    localparam logic [FP_W-1:0]  FP_RESET = FP_W'(2105376);
    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

    // Configuration register indexes.
    localparam int REG_FRAME_PIXELS = 0;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_last;
    } t_pixel_in;

    typedef struct packed {
        logic [LUMA_W-1:0] frame_mean;
        logic [LUMA_W-1:0] smoothed_luma;
    } t_luma_out;

    // One closed frame, handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_frame_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMA
    } t_back_state;

    // First window position for a frame of fp pixels.
    function automatic logic [POS_W-1:0] calc_win_start(input logic [FP_W-1:0] fp);
        logic [FP_W-1:0] diff;
        diff = fp - FP_W'(SAMPLE_PIXELS);
        if (fp > FP_W'(SAMPLE_PIXELS)) begin
            return POS_W'(diff >> 1);
        end else begin
            return '0;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/cwle_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwle_queue
// Two-entry queue of closed frame statistics between front and back.
// ----------------------------------------------------------------------------
module cwle_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire cwle_pkg::t_frame_stat i_push_data,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_not_empty,
    output cwle_pkg::t_frame_stat      o_pop_data
);
    import cwle_pkg::*;

    localparam int DEPTH = 2;
    localparam int IDX_W = $clog2(DEPTH);

    t_frame_stat             r_store [DEPTH];
    logic [IDX_W-1:0]        r_wr_ptr;
    logic [IDX_W-1:0]        r_rd_ptr;
    logic [$clog2(DEPTH+1)-1:0] r_count;

    assign o_full      = (r_count == ($clog2(DEPTH+1))'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_pop_data  = r_store[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full frame queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_not_empty |-> !i_pop)
        else $error("pop from an empty frame queue");

endmodule
`default_nettype wire

// ===== design/cwle_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwle_front
// Takes one pixel per cycle while the queue is not full, sums the center window and closes each frame.
// ----------------------------------------------------------------------------
module cwle_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire cwle_pkg::t_pixel_in             i_in_data,
    input  wire logic [cwle_pkg::FP_W-1:0]       i_frame_pixels,
    input  wire logic [cwle_pkg::POS_W-1:0]      i_win_start,
    output logic                                 o_push,
    output cwle_pkg::t_frame_stat                o_push_data,
    input  wire logic                            i_queue_full
);
    import cwle_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;

    logic             accept;
    logic             hit;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_count;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        hit = (r_pos >= i_win_start) && ({1'b0, r_pos} < i_frame_pixels)
              && (r_count < CNT_W'(SAMPLE_PIXELS));
        n_sum   = r_sum;
        n_count = r_count;
        if (hit) begin
            n_sum   = r_sum + {{(SUM_W-PIXEL_W){1'b0}}, i_in_data.pixel};
            n_count = r_count + 1'b1;
        end
    end

    assign o_push            = accept && i_in_data.frame_last;
    assign o_push_data.sum   = n_sum;
    assign o_push_data.count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (i_in_data.frame_last) begin
                r_pos   <= '0;
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SAMPLE_PIXELS))
        else $error("window count above the sample limit");

endmodule
`default_nettype wire

// ===== design/cwle_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwle_back
// Divides each frame's window sum by its count one quotient bit per cycle,
// then updates the smoothed luma and holds the result for the consumer.
// ----------------------------------------------------------------------------
module cwle_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_not_empty,
    input  wire cwle_pkg::t_frame_stat i_pop_data,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output cwle_pkg::t_luma_out        o_out_data
);
    import cwle_pkg::*;

    localparam int REM_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int MIX_W  = LUMA_W + 5;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [SUM_W-1:0]  r_dq;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic [LUMA_W-1:0] r_avg;
    logic              r_seeded;
    logic              r_out_valid;
    t_luma_out         r_out;

    logic [REM_W-1:0]  trial;
    logic              fits;
    logic [LUMA_W-1:0] mean;
    logic [MIX_W-1:0]  mix;
    logic [LUMA_W-1:0] n_avg;
    logic              emit;

    assign o_valid    = r_out_valid;
    assign o_out_data = r_out;

    always_comb begin
        trial = {r_rem, r_dq[SUM_W-1]};
        fits  = (trial >= {1'b0, r_div});
        // An empty window carries a zero sum, so the quotient is skipped.
        mean  = (r_div == '0) ? '0 : r_dq[LUMA_W+1:2];
        mix   = {r_avg, 5'b0} - {5'b0, r_avg} + {5'b0, mean};
        n_avg = r_seeded ? mix[MIX_W-1:5] : mean;
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        emit    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_not_empty) begin
                    o_pop   = 1'b1;
                    n_state = (i_pop_data.count == '0) ? BK_EMA : BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == '0) begin
                    n_state = BK_EMA;
                end
            end
            BK_EMA: begin
                if (!r_out_valid || i_ready) begin
                    emit    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_avg       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_avg       <= n_avg;
                r_seeded    <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dq   <= i_pop_data.sum;
            r_rem  <= '0;
            r_div  <= i_pop_data.count;
            r_step <= STEP_W'(SUM_W - 1);
        end else if (r_state == BK_DIV) begin
            r_dq   <= {r_dq[SUM_W-2:0], fits};
            r_rem  <= fits ? CNT_W'(trial - {1'b0, r_div}) : CNT_W'(trial);
            r_step <= r_step - 1'b1;
        end
        if (emit) begin
            r_out.frame_mean    <= mean;
            r_out.smoothed_luma <= n_avg;
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_DIV |-> r_div != '0)
        else $error("divide started with an empty window");

    a_emit_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_seeded && r_out_valid)
        else $error("result loaded without seeding the average");

endmodule
`default_nettype wire

// ===== design/center_window_luma_ema.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// center_window_luma_ema
// Mean luma of a centered pixel window per frame, smoothed across frames.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  pixel    | in        | i_valid / o_ready    | i_in_data (pixel, frame_last)
//  luma     | out       | o_valid / i_ready    | o_out_data (frame_mean, smoothed_luma)
//  config   | in        | psel/penable/pready  | paddr, pwdata, prdata (frame_pixels)
//
// Pixels are taken one per cycle while o_ready is high; the window sum is kept
// in the front stage. Each closed frame waits in a two-entry queue; the back
// stage loads it, runs the bit-serial divide and then updates the smoothed luma.
// o_ready drops only while the queue holds two frames not yet started.
// Reset is synchronous; no memory needs clearing.
// ----------------------------------------------------------------------------
module center_window_luma_ema (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire cwle_pkg::t_pixel_in  i_in_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output cwle_pkg::t_luma_out       o_out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import cwle_pkg::*;

    localparam logic [POS_W-1:0] WIN_START_RESET = calc_win_start(FP_RESET);

    logic [FP_W-1:0]  r_frame_pixels;
    logic [POS_W-1:0] r_win_start;
    logic             cfg_write;
    logic             sel_fp;

    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_not_empty;
    t_frame_stat      push_data;
    t_frame_stat      pop_data;

    assign pready    = 1'b1;
    assign sel_fp    = (32'(paddr[2]) == REG_FRAME_PIXELS);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = sel_fp ? {{(32-FP_W){1'b0}}, r_frame_pixels} : '0;

    // The window start is worked out once per write, off the pixel path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FP_RESET;
            r_win_start    <= WIN_START_RESET;
        end else if (cfg_write && sel_fp) begin
            r_frame_pixels <= pwdata[FP_W-1:0];
            r_win_start    <= calc_win_start(pwdata[FP_W-1:0]);
        end
    end

    cwle_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_data      (i_in_data),
        .i_frame_pixels (r_frame_pixels),
        .i_win_start    (r_win_start),
        .o_push         (push),
        .o_push_data    (push_data),
        .i_queue_full   (queue_full)
    );

    cwle_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_not_empty (queue_not_empty),
        .o_pop_data  (pop_data)
    );

    cwle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (queue_not_empty),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the center window luma average against a cycle-free predictor.
// Short directed sequences cover empty windows, extreme pixels, a window that
// starts past zero, register writes between and inside frames, and the
// unused register address. Random frames follow, with stalls on both sides.
// Every luma result is compared field by field with the predicted or typed-in value.
// ----------------------------------------------------------------------------
module testbench;
    import cwle_pkg::*;

    localparam int IDLE_PCT     = 38;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int STEADY_FROM  = 300;
    localparam int STEADY_TO    = 500;
    localparam int REG_UNUSED   = 1;
    localparam int EMA_KEEP     = 31;
    localparam int EMA_DIV      = 32;
    localparam int WIDE_PHASE   = 2;

    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        last;
        logic        typed;
        t_luma_out   res;
    } t_stim_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    t_pixel_in   i_in_data  = '0;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    t_luma_out   o_out_data;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    // Typed-in expectation that travels alongside the request being offered.
    logic        typed_on   = 1'b0;
    t_luma_out   typed_res  = '0;

    bit          steady_run = 1'b0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    t_luma_out   luma_expected[$];

    // Predictor state, reset values included.
    logic [FP_W-1:0]   fp_setting = FP_RESET;
    logic [POS_W-1:0]  frame_pos  = '0;
    logic [SUM_W-1:0]  win_sum    = '0;
    logic [CNT_W-1:0]  win_count  = '0;
    logic [LUMA_W-1:0] avg_luma   = '0;
    logic              avg_seeded = 1'b0;

    center_window_luma_ema DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Adds one pixel to the running frame; returns 1 when it closes the frame.
    function automatic bit accumulate_pixel(input t_pixel_in px, output t_luma_out res);
        logic [31:0]       fp32;
        logic [31:0]       start32;
        logic [LUMA_W-1:0] mean;
        fp32    = 32'(fp_setting);
        start32 = (fp32 > SAMPLE_PIXELS) ? (fp32 - SAMPLE_PIXELS) / 2 : 32'd0;
        res     = '0;
        if (32'(frame_pos) >= start32 && 32'(frame_pos) < fp32 &&
            32'(win_count) < SAMPLE_PIXELS) begin
            win_sum   = win_sum + SUM_W'(px.pixel);
            win_count = win_count + 1'b1;
        end
        if (!px.frame_last) begin
            if (frame_pos != POS_MAX) begin
                frame_pos = frame_pos + 1'b1;
            end
            return 1'b0;
        end
        mean = '0;
        if (win_count != '0) begin
            mean = LUMA_W'((32'(win_sum) / 32'(win_count)) >> 2);
        end
        if (avg_seeded) begin
            avg_luma = LUMA_W'((32'(avg_luma) * EMA_KEEP + 32'(mean)) / EMA_DIV);
        end else begin
            avg_luma = mean;
        end
        avg_seeded        = 1'b1;
        frame_pos         = '0;
        win_sum           = '0;
        win_count         = '0;
        res.frame_mean    = mean;
        res.smoothed_luma = avg_luma;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_luma_out want;
        t_luma_out predicted;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (luma_expected.size() == 0) begin
                    $error("luma result with none expected: frame_mean %0d, smoothed_luma %0d",
                           o_out_data.frame_mean, o_out_data.smoothed_luma);
                    fail_count++;
                end else begin
                    want = luma_expected.pop_front();
                    if (o_out_data.frame_mean !== want.frame_mean) begin
                        $error("frame_mean: expected %0d, got %0d",
                               want.frame_mean, o_out_data.frame_mean);
                        fail_count++;
                    end
                    if (o_out_data.smoothed_luma !== want.smoothed_luma) begin
                        $error("smoothed_luma: expected %0d, got %0d",
                               want.smoothed_luma, o_out_data.smoothed_luma);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_FRAME_PIXELS)) begin
                fp_setting = pwdata[FP_W-1:0];
            end
            if (i_valid && o_ready) begin
                if (accumulate_pixel(i_in_data, predicted)) begin
                    luma_expected.push_back(typed_on ? typed_res : predicted);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic last,
                              input logic typed, input t_luma_out res);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_data <= '{pixel: px, frame_last: last};
        typed_on  <= typed;
        typed_res <= res;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Holds the pixel side off until every frame result is back and the
    // back stage has had time to settle. The first edge lets the monitor
    // record a frame closed at the edge the caller returned on.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (luma_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int idx, input logic [31:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_FRAME_PIXELS && prdata !== 32'(value[FP_W-1:0])) begin
            $error("frame_pixels: expected %0d, got %0d", value[FP_W-1:0], prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_stim_row px_row(input logic [PIXEL_W-1:0] px, input logic last,
                                         input logic typed = 1'b0,
                                         input logic [LUMA_W-1:0] mean = '0,
                                         input logic [LUMA_W-1:0] avg = '0);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_PIXEL;
        row.value = 32'(px);
        row.last  = last;
        row.typed = typed;
        row.res   = '{frame_mean: mean, smoothed_luma: avg};
        return row;
    endfunction

    function automatic t_stim_row wr_row(input int idx, input logic [31:0] value);
        t_stim_row row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = 2'(idx);
        row.value   = value;
        return row;
    endfunction

    initial begin : stimulus
        t_stim_row   directed_rows[$];
        t_stim_row   row;
        int unsigned random_sent;
        int unsigned phase_idx;
        int          fp_cur;
        int          flen;
        int          frames;
        logic [31:0] fp_new;
        logic [PIXEL_W-1:0] px;

        // The reset window starts far past any short frame, so it is empty.
        directed_rows.push_back(px_row(PIXEL_MAX, 1'b1, 1'b1, 8'd0, 8'd0));
        directed_rows.push_back(wr_row(REG_FRAME_PIXELS, 0));
        directed_rows.push_back(px_row(PIXEL_MAX, 1'b1, 1'b1, 8'd0, 8'd0));
        directed_rows.push_back(wr_row(REG_FRAME_PIXELS, 1));
        directed_rows.push_back(px_row(PIXEL_MAX, 1'b1, 1'b1, 8'd255, 8'd7));
        // Frame longer than the setting: the tail is ignored.
        directed_rows.push_back(wr_row(REG_FRAME_PIXELS, 4));
        repeat (4) directed_rows.push_back(px_row(PIXEL_MAX, 1'b0));
        directed_rows.push_back(px_row(0, 1'b0));
        directed_rows.push_back(px_row(0, 1'b1));
        // Frame shorter than the setting.
        directed_rows.push_back(px_row(0, 1'b0));
        directed_rows.push_back(px_row(0, 1'b1));
        // The setting changes after the first pixel of a frame.
        directed_rows.push_back(px_row(512, 1'b0));
        directed_rows.push_back(wr_row(REG_FRAME_PIXELS, 0));
        directed_rows.push_back(px_row(PIXEL_MAX, 1'b1));
        directed_rows.push_back(wr_row(REG_UNUSED, 32'd8));
        directed_rows.push_back(px_row(700, 1'b1));
        // Window starts at position two.
        directed_rows.push_back(wr_row(REG_FRAME_PIXELS, SAMPLE_PIXELS + 4));
        directed_rows.push_back(px_row(1, 1'b0));
        directed_rows.push_back(px_row(2, 1'b0));
        directed_rows.push_back(px_row(PIXEL_MAX, 1'b0));
        directed_rows.push_back(px_row(1022, 1'b0));
        directed_rows.push_back(px_row(3, 1'b1));
        directed_rows.push_back(wr_row(REG_FRAME_PIXELS, 32'hFFFF_FFFF));
        directed_rows.push_back(px_row(PIXEL_MAX, 1'b1));
        directed_rows.push_back(wr_row(REG_FRAME_PIXELS, 4194304));
        directed_rows.push_back(px_row(10'h155, 1'b0));
        directed_rows.push_back(px_row(10'h2AA, 1'b1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_WRITE) begin
                cfg_write(int'(row.reg_idx), row.value);
            end else begin
                send_pixel(row.value[PIXEL_W-1:0], row.last, row.typed, row.res);
            end
        end

        random_sent = 0;
        phase_idx   = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase_idx == WIDE_PHASE) begin
                fp_new = $urandom_range(SAMPLE_PIXELS + 1, SAMPLE_PIXELS + 14);
            end else begin
                case ($urandom_range(9))
                    0: fp_new = 0;
                    1: fp_new = $urandom;
                    2: fp_new = 4194304;
                    default: fp_new = $urandom_range(1, 24);
                endcase
            end
            if ($urandom_range(9) == 0) begin
                cfg_write(REG_UNUSED, $urandom);
            end
            cfg_write(REG_FRAME_PIXELS, fp_new);
            fp_cur = int'(fp_new[FP_W-1:0]);
            frames = (phase_idx == WIDE_PHASE) ? 1 : $urandom_range(2, 8);

            repeat (frames) begin
                if (phase_idx == WIDE_PHASE) begin
                    // Long enough that the window fills before the frame ends.
                    flen = fp_cur + $urandom_range(0, 3);
                end else if (fp_cur == 0 || fp_cur > 64) begin
                    flen = $urandom_range(1, 24);
                end else begin
                    case ($urandom_range(9))
                        0: flen = 1;
                        1, 2: flen = $urandom_range(1, 2 * fp_cur + 2);
                        default: flen = fp_cur + $urandom_range(0, 4) - 2;
                    endcase
                    if (flen < 1) begin
                        flen = 1;
                    end
                end
                if ($urandom_range(15) == 0) begin
                    wait_drained();
                end
                for (int i = 0; i < flen; i++) begin
                    case ($urandom_range(9))
                        0: px = '0;
                        1: px = PIXEL_MAX;
                        default: px = $urandom_range(0, PIXEL_MAX);
                    endcase
                    steady_run = (random_sent >= STEADY_FROM && random_sent < STEADY_TO);
                    send_pixel(px, (i == flen - 1), 1'b0, '0);
                    if (phase_idx != WIDE_PHASE) begin
                        random_sent++;
                    end
                end
            end
            phase_idx++;
        end

        steady_run = 1'b0;
        wait_drained();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
